// ===== src/sppp_pkg.sv =====
// Shared types and constants for the planar-to-packed sprite tile converter.
package sppp_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned ROW_W       = 4;
    localparam int unsigned PIXELS      = 8;
    localparam int unsigned PIX_CNT_W   = 4;
    localparam int unsigned TILE_CNT_W  = 9;

    localparam logic [TILE_CNT_W-1:0] FULL_TILE_PENS = 9'd256;

    typedef logic [WORD_W-1:0]     t_word;
    typedef logic [POS_W-1:0]      t_pos;
    typedef logic [ROW_W-1:0]      t_row;
    typedef logic [PIX_CNT_W-1:0]  t_pix_cnt;
    typedef logic [TILE_CNT_W-1:0] t_tile_cnt;

    typedef enum logic [1:0] {
        USAGE_BLANK   = 2'd0,
        USAGE_PARTIAL = 2'd1,
        USAGE_OPAQUE  = 2'd2
    } t_usage;

endpackage

// ===== src/sppp_store.sv =====
// Sixteen-entry store for the first half of a tile, with registered read data.
module sppp_store (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  sppp_pkg::t_row    i_wr_addr,
    input  sppp_pkg::t_word   i_wr_data,
    input  logic              i_rd_en,
    input  sppp_pkg::t_row    i_rd_addr,
    output sppp_pkg::t_word   o_rd_data
);
    import sppp_pkg::*;

    t_word r_mem [16];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/sppp_conv.sv =====
// Converts one planar word into eight packed pens and counts the non-zero pens.
module sppp_conv (
    input  sppp_pkg::t_word    i_word,
    output sppp_pkg::t_word    o_packed,
    output sppp_pkg::t_pix_cnt o_pen_cnt
);
    import sppp_pkg::*;

    logic [PIXELS-1:0] nonzero;

    // Output nibble k holds pixel k/2 for even k and pixel 4+k/2 for odd k.
    always_comb begin
        for (int k = 0; k < PIXELS; k++) begin
            logic [3:0] pen;
            pen = {i_word[24 + ((k % 2) * 4) + (k / 2)],
                   i_word[8  + ((k % 2) * 4) + (k / 2)],
                   i_word[16 + ((k % 2) * 4) + (k / 2)],
                   i_word[     ((k % 2) * 4) + (k / 2)]};
            o_packed[k*4 +: 4] = pen;
            nonzero[k]         = |pen;
        end
    end

    assign o_pen_cnt = t_pix_cnt'($countones(nonzero));

endmodule

// ===== src/sprite_planar_to_packed_core.sv =====
// Top level of the planar-to-packed 16x16 sprite tile converter.
// Words 0..15 of a tile are stored and give no result; each of words 16..31 gives two
// results. A second-half word is held in a word register, and its results pass through
// the single output register at one result per cycle while the output is not stalled;
// its successor is taken as its last result loads. First-half words go in one per cycle.
// Synchronous active-low reset clears the word position, pen count and valid flags.
module sprite_planar_to_packed_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sppp_pkg::t_word   i_data_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sppp_pkg::t_word   o_packed_word,
    output logic              o_run_last,
    output logic              o_tile_end,
    output logic [1:0]        o_pen_usage
);
    import sppp_pkg::*;

    t_pos      r_pos, n_pos;
    t_tile_cnt r_count, n_count;

    logic      r_a_valid, n_a_valid;
    logic      r_a_last;
    t_word     r_a_word;
    logic      r_phase, n_phase;

    logic      r_o_valid, n_o_valid;
    t_word     r_o_packed;
    logic      r_o_run_last;
    logic      r_o_tile_end;
    t_usage    r_o_usage;

    t_word     stored_word;
    t_word     packed_new, packed_old;
    t_pix_cnt  cnt_new, cnt_old;
    t_tile_cnt tile_total;
    t_usage    usage;

    logic      in_fire, first_half, out_load, a_done;

    assign first_half = ~r_pos[POS_W-1];
    assign out_load   = r_a_valid && (!r_o_valid || i_out_ready);
    assign a_done     = out_load && r_phase;
    // First-half words only touch the store, so they never wait on the result side.
    assign o_in_ready = first_half || !r_a_valid || a_done;
    assign in_fire    = i_in_valid && o_in_ready;

    sppp_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_fire && first_half),
        .i_wr_addr (r_pos[ROW_W-1:0]),
        .i_wr_data (i_data_word),
        .i_rd_en   (in_fire && !first_half),
        .i_rd_addr (r_pos[ROW_W-1:0]),
        .o_rd_data (stored_word)
    );

    sppp_conv u_conv_new (
        .i_word    (r_a_word),
        .o_packed  (packed_new),
        .o_pen_cnt (cnt_new)
    );

    sppp_conv u_conv_old (
        .i_word    (stored_word),
        .o_packed  (packed_old),
        .o_pen_cnt (cnt_old)
    );

    assign tile_total = r_count + t_tile_cnt'(cnt_old);

    always_comb begin
        if (tile_total == '0) begin
            usage = USAGE_BLANK;
        end else if (tile_total == FULL_TILE_PENS) begin
            usage = USAGE_OPAQUE;
        end else begin
            usage = USAGE_PARTIAL;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_count   = r_count;
        n_a_valid = r_a_valid;
        n_phase   = r_phase;
        n_o_valid = r_o_valid;

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end
        if (out_load) begin
            n_o_valid = 1'b1;
            if (!r_phase) begin
                n_phase = 1'b1;
                n_count = r_count + t_tile_cnt'(cnt_new);
            end else begin
                n_phase   = 1'b0;
                n_a_valid = 1'b0;
                n_count   = r_a_last ? '0 : tile_total;
            end
        end
        if (in_fire) begin
            n_pos = r_pos + 1'b1;
            if (!first_half) begin
                n_a_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_count   <= '0;
            r_a_valid <= 1'b0;
            r_phase   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_a_valid <= n_a_valid;
            r_phase   <= n_phase;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && !first_half) begin
            r_a_word <= i_data_word;
            r_a_last <= (r_pos == t_pos'(31));
        end
        if (out_load) begin
            if (!r_phase) begin
                r_o_packed   <= packed_new;
                r_o_run_last <= 1'b0;
                r_o_tile_end <= 1'b0;
                r_o_usage    <= USAGE_BLANK;
            end else begin
                r_o_packed   <= packed_old;
                r_o_run_last <= 1'b1;
                r_o_tile_end <= r_a_last;
                r_o_usage    <= r_a_last ? usage : USAGE_BLANK;
            end
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_packed_word = r_o_packed;
    assign o_run_last    = r_o_run_last;
    assign o_tile_end    = r_o_tile_end;
    assign o_pen_usage   = r_o_usage;

endmodule
